// ----- hw/rtl/vfc_pkg.sv -----
package vfc_pkg;

  // Field widths fixed by the item formats.
  localparam int COORD_W = 4;
  localparam int KIND_W  = 6;
  localparam int FACE_W  = 3;
  localparam int MASK_W  = 64;
  localparam int NUM_FACES = 6;

  // Face codes, in emission order.
  localparam logic [FACE_W-1:0] FACE_ZN = 3'd0;
  localparam logic [FACE_W-1:0] FACE_ZP = 3'd1;
  localparam logic [FACE_W-1:0] FACE_XN = 3'd2;
  localparam logic [FACE_W-1:0] FACE_XP = 3'd3;
  localparam logic [FACE_W-1:0] FACE_YN = 3'd4;
  localparam logic [FACE_W-1:0] FACE_YP = 3'd5;

  // Operation codes.
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic [KIND_W-1:0]  node_kind;
  } in_item_t;

  typedef struct packed {
    logic               face_valid;
    logic [FACE_W-1:0]  face_dir;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_z;
    logic [KIND_W-1:0]  out_kind;
    logic               last;
  } out_item_t;

endpackage

// ----- hw/rtl/voxel_face_culling.sv -----
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   in_data (in_item_t)
// out       output     out_valid/out_stall out_data (out_item_t)
// cfg       input      cfg_we              cfg_data (visible mask)
//
// A store is written to the store as it is accepted. A query first reads
// the node, then, if the node is visible, reads its six neighbors one at a time
// through the single read port of the store, then sends one record per cycle
// while out is not stalled. Reset clears the control state and the visible
// mask; store contents stay undefined until written. A stall on out holds the
// record and, while records are being sent, the sequencer.
module voxel_face_culling import vfc_pkg::*; #(
  parameter int EDGE       = 16,
  parameter int NODE_TYPES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [MASK_W-1:0] cfg_data
);

  localparam int DEPTH = EDGE * EDGE * EDGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int EXT_W = ($clog2(EDGE + 1) > COORD_W) ? $clog2(EDGE + 1) : COORD_W;
  localparam logic [EXT_W-1:0] EDGE_L   = EXT_W'(EDGE);
  localparam logic [EXT_W-1:0] EDGE_MAX = EXT_W'(EDGE - 1);
  localparam logic [FACE_W-1:0] LAST_FACE = FACE_W'(NUM_FACES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CEN  = 2'd1;
  localparam logic [1:0] S_NBR  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]           state;
  logic [MASK_W-1:0]    visible_mask;
  logic [COORD_W-1:0]   cx, cy, cz;
  logic                 qinside;
  logic [KIND_W-1:0]    kind;
  logic [FACE_W-1:0]    cursor;
  logic [NUM_FACES-1:0] expose;

  logic                 in_xfer;
  logic                 in_inside;
  logic                 out_free;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic [KIND_W-1:0]    mem_rdata;
  logic [KIND_W-1:0]    cen_kind;
  logic                 nbr_exposed;
  logic [FACE_W-1:0]    read_face;
  logic [NUM_FACES-1:0] low_bit;
  logic [FACE_W-1:0]    low_face;
  logic [NUM_FACES-1:0] expose_left;

  function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [COORD_W-1:0] z);
    cell_addr = AW'((32'(x) * EDGE + 32'(y)) * EDGE + 32'(z));
  endfunction

  function automatic logic coord_inside(input logic [COORD_W-1:0] c);
    coord_inside = EXT_W'(c) < EDGE_L;
  endfunction

  function automatic logic kind_visible(input logic [MASK_W-1:0] m,
                                        input logic [KIND_W-1:0] k);
    kind_visible = (7'(k) < 7'(NODE_TYPES)) && m[k];
  endfunction

  // True when the face looks out of the block.
  function automatic logic on_boundary(input logic [FACE_W-1:0] f,
                                       input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y,
                                       input logic [COORD_W-1:0] z);
    case (f)
      FACE_ZN: on_boundary = (z == '0);
      FACE_ZP: on_boundary = (EXT_W'(z) == EDGE_MAX);
      FACE_XN: on_boundary = (x == '0);
      FACE_XP: on_boundary = (EXT_W'(x) == EDGE_MAX);
      FACE_YN: on_boundary = (y == '0);
      FACE_YP: on_boundary = (EXT_W'(y) == EDGE_MAX);
      default: on_boundary = 1'b1;
    endcase
  endfunction

  // Neighbor address; a face on the boundary reads the node itself.
  function automatic logic [AW-1:0] nbr_addr(input logic [FACE_W-1:0] f,
                                             input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y,
                                             input logic [COORD_W-1:0] z);
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] nz;
    nx = x;
    ny = y;
    nz = z;
    if (!on_boundary(f, x, y, z)) begin
      case (f)
        FACE_ZN: nz = z - 1'b1;
        FACE_ZP: nz = z + 1'b1;
        FACE_XN: nx = x - 1'b1;
        FACE_XP: nx = x + 1'b1;
        FACE_YN: ny = y - 1'b1;
        FACE_YP: ny = y + 1'b1;
        default: nx = x;
      endcase
    end
    nbr_addr = cell_addr(nx, ny, nz);
  endfunction

  vfc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data.node_kind),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Input side: items are taken only while the sequencer is idle.
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign in_inside = coord_inside(in_data.pos_x) && coord_inside(in_data.pos_y) &&
                     coord_inside(in_data.pos_z);
  assign out_free  = !out_valid || !out_stall;

  assign mem_we    = in_xfer && (in_data.func == FUNC_STORE) && in_inside;
  assign mem_waddr = cell_addr(in_data.pos_x, in_data.pos_y, in_data.pos_z);

  // Read port: node on accept, then neighbors in face order.
  assign read_face = (state == S_CEN) ? FACE_ZN : cursor + 1'b1;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = nbr_addr(read_face, cx, cy, cz);
    case (state)
      S_IDLE: begin
        mem_re    = in_xfer && (in_data.func == FUNC_QUERY);
        mem_raddr = mem_waddr;
      end
      S_CEN:   mem_re = 1'b1;
      S_NBR:   mem_re = (cursor != LAST_FACE);
      default: mem_re = 1'b0;
    endcase
  end

  assign cen_kind    = qinside ? mem_rdata : '0;
  assign nbr_exposed = on_boundary(cursor, cx, cy, cz) ||
                       !kind_visible(visible_mask, mem_rdata);

  // Lowest exposed face still to be sent.
  always_comb begin
    low_bit  = '0;
    low_face = FACE_ZN;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (expose[i]) begin
        low_bit  = NUM_FACES'(1) << i;
        low_face = FACE_W'(i);
      end
    end
  end

  assign expose_left = expose & ~low_bit;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer && (in_data.func == FUNC_QUERY)) begin
            state <= S_CEN;
          end
        end
        S_CEN: begin
          if (qinside && kind_visible(visible_mask, cen_kind)) begin
            state <= S_NBR;
          end else begin
            state <= S_EMIT;
          end
        end
        S_NBR: begin
          if (cursor == LAST_FACE) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free && (expose_left == '0)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Query context and exposure bits.
  always_ff @(posedge clk) begin
    if (in_xfer && (in_data.func == FUNC_QUERY)) begin
      cx      <= in_data.pos_x;
      cy      <= in_data.pos_y;
      cz      <= in_data.pos_z;
      qinside <= in_inside;
    end
    if (state == S_CEN) begin
      kind   <= cen_kind;
      cursor <= FACE_ZN;
      expose <= '0;
    end
    if (state == S_NBR) begin
      expose[cursor] <= nbr_exposed;
      cursor         <= cursor + 1'b1;
    end
    if ((state == S_EMIT) && out_free) begin
      expose <= expose_left;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_data.face_valid <= (expose != '0);
      out_data.face_dir   <= low_face;
      out_data.out_x      <= cx;
      out_data.out_y      <= cy;
      out_data.out_z      <= cz;
      out_data.out_kind   <= kind;
      out_data.last       <= (expose_left == '0);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      visible_mask <= '0;
    end else if (cfg_we) begin
      visible_mask <= cfg_data;
    end
  end

endmodule

// ----- hw/rtl/vfc_store.sv -----
module vfc_store import vfc_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [KIND_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [KIND_W-1:0] rdata
);

  logic [KIND_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
